### hdl/ncp_pkg.sv
// ncp_pkg: widths, beat types and constants of the normalized cross product block.
// No dependencies; imported by every module under hdl.
package ncp_pkg;

  localparam int COORD_W    = 16;
  localparam int UNIT_F     = 15;
  localparam int OUT_W      = UNIT_F + 1;
  localparam int MAG_W      = 2 * COORD_W;
  localparam int VEC_W      = MAG_W + 1;
  localparam int SUM_W      = 2 * MAG_W;
  localparam int ROOT_W     = MAG_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int Q_W        = UNIT_F + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    OP_NORM  = 1'b0,
    OP_CROSS = 1'b1
  } op_t;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    zero_length;
  } out_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  // handshake between the mid queue and the back end
  typedef struct packed {
    logic empty;
    logic pop;
  } qctl_t;

endpackage

### hdl/ncp_front.sv
// ncp_front: input register with the six cross-product multipliers, then
// forms the vector to normalise. Depends on ncp_pkg.
module ncp_front import ncp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic q_push,
  input  logic q_full,
  output vec_t q_data
);

  logic                    f_v_r, f_v_nxt;
  logic                    f_op_r;
  logic signed [COORD_W-1:0] ax_r, ay_r, az_r;
  logic signed [MAG_W-1:0] p_r [6];
  logic                    take;

  assign q_push  = f_v_r && !q_full;
  assign in_full = f_v_r && q_full;
  assign take    = in_push && !in_full;
  assign f_v_nxt = take || (f_v_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_op_r <= in_data.op;
      ax_r   <= in_data.a_x;
      ay_r   <= in_data.a_y;
      az_r   <= in_data.a_z;
      p_r[0] <= in_data.a_y * in_data.b_z;
      p_r[1] <= in_data.a_z * in_data.b_y;
      p_r[2] <= in_data.a_z * in_data.b_x;
      p_r[3] <= in_data.a_x * in_data.b_z;
      p_r[4] <= in_data.a_x * in_data.b_y;
      p_r[5] <= in_data.a_y * in_data.b_x;
    end
  end

  always_comb begin
    if (op_t'(f_op_r) == OP_CROSS) begin
      q_data.x = VEC_W'(p_r[0]) - VEC_W'(p_r[1]);
      q_data.y = VEC_W'(p_r[2]) - VEC_W'(p_r[3]);
      q_data.z = VEC_W'(p_r[4]) - VEC_W'(p_r[5]);
    end else begin
      q_data.x = VEC_W'(ax_r);
      q_data.y = VEC_W'(ay_r);
      q_data.z = VEC_W'(az_r);
    end
  end

endmodule

### hdl/ncp_fifo.sv
// ncp_fifo: short queue of vectors between the front and back ends.
// Depends on ncp_pkg.
module ncp_fifo import ncp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  vec_t  wdata,
  input  qctl_t ctl_i,
  output logic  empty,
  output vec_t  rdata
);

  vec_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_pop;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign do_pop = ctl_i.pop && !ctl_i.empty;
  assign rdata  = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

endmodule

### hdl/ncp_back.sv
// ncp_back: magnitudes, squares, sum, pipelined square root, pipelined
// dividers and the result register. Depends on ncp_pkg.
module ncp_back import ncp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  vec_t  q_data,
  output qctl_t q_ctl,
  output logic  out_empty,
  input  logic  out_pop,
  output out_t  out_data
);

  typedef struct packed {
    logic [2:0]            sgn;
    logic [2:0][MAG_W-1:0] mag;
    logic [SUM_W-1:0]      s;
    logic [ROOT_W-1:0]     root;
    logic [REM_W-1:0]      rem;
    logic                  zero;
  } sq_t;

  typedef struct packed {
    logic [2:0]            sgn;
    logic [ROOT_W-1:0]     d;
    logic [2:0][MAG_W-1:0] r;
    logic [2:0][Q_W-1:0]   q;
    logic                  zero;
  } dv_t;

  function automatic sq_t sqrt_step(sq_t a);
    logic [REM_W+1:0] rsh;
    logic [REM_W+1:0] trial;
    sq_t              b;
    b     = a;
    rsh   = {a.rem, a.s[SUM_W-1 -: 2]};
    trial = {2'b00, a.root, 2'b01};
    if (rsh >= trial) begin
      b.rem  = REM_W'(rsh - trial);
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = REM_W'(rsh);
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    b.s = {a.s[SUM_W-3:0], 2'b00};
    return b;
  endfunction

  function automatic dv_t div_step(dv_t a, logic first);
    logic [MAG_W:0] t;
    dv_t            b;
    b = a;
    for (int c = 0; c < 3; c++) begin
      t = first ? {1'b0, a.r[c]} : {a.r[c], 1'b0};
      if (t >= {1'b0, a.d}) begin
        b.r[c] = MAG_W'(t - {1'b0, a.d});
        b.q[c] = {a.q[c][Q_W-2:0], 1'b1};
      end else begin
        b.r[c] = MAG_W'(t);
        b.q[c] = {a.q[c][Q_W-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  logic adv;
  logic out_v_r;
  out_t out_r;

  assign adv       = !out_v_r || out_pop;
  assign q_ctl     = '{empty: q_empty, pop: adv};
  assign out_empty = !out_v_r;
  assign out_data  = out_r;

  // magnitude, square and sum stages
  logic                    m_v_r, p_v_r;
  logic [2:0]              m_sgn_r, p_sgn_r;
  logic [2:0][MAG_W-1:0]   m_mag_r, p_mag_r;
  logic [2:0][SUM_W-1:0]   p_sq_r;
  logic signed [VEC_W-1:0] vin [3];
  logic [VEC_W-1:0]        vabs [3];
  sq_t                     sq_r [ROOT_W+1];
  logic                    sq_v_r [ROOT_W+1];
  dv_t                     dv_r [Q_W+1];
  logic                    dv_v_r [Q_W+1];
  logic [SUM_W-1:0]        sum;

  assign vin[0] = q_data.x;
  assign vin[1] = q_data.y;
  assign vin[2] = q_data.z;
  assign sum    = p_sq_r[0] + p_sq_r[1] + p_sq_r[2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vabs[c] = vin[c][VEC_W-1] ? VEC_W'(-vin[c]) : VEC_W'(vin[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r     <= 1'b0;
      p_v_r     <= 1'b0;
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      m_v_r     <= !q_empty;
      p_v_r     <= m_v_r;
      sq_v_r[0] <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        m_sgn_r[c] <= vin[c][VEC_W-1];
        m_mag_r[c] <= vabs[c][MAG_W-1:0];
        p_sq_r[c]  <= m_mag_r[c] * m_mag_r[c];
      end
      p_sgn_r         <= m_sgn_r;
      p_mag_r         <= m_mag_r;
      sq_r[0].sgn     <= p_sgn_r;
      sq_r[0].mag     <= p_mag_r;
      sq_r[0].s       <= sum;
      sq_r[0].root    <= '0;
      sq_r[0].rem     <= '0;
      sq_r[0].zero    <= (sum == '0);
    end
  end

  for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[gi+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[gi+1] <= sq_v_r[gi];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) sq_r[gi+1] <= sqrt_step(sq_r[gi]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].sgn  <= sq_r[ROOT_W].sgn;
      dv_r[0].d    <= sq_r[ROOT_W].root;
      dv_r[0].r    <= sq_r[ROOT_W].mag;
      dv_r[0].q    <= '0;
      dv_r[0].zero <= sq_r[ROOT_W].zero;
    end
  end

  for (genvar gj = 0; gj < Q_W; gj++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[gj+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[gj+1] <= dv_v_r[gj];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) dv_r[gj+1] <= div_step(dv_r[gj], (gj == 0));
    end
  end

  // rounding, saturation and zero-length override
  logic [Q_W:0]          qp [3];
  logic [Q_W-1:0]        mg [3];
  logic [2:0][OUT_W-1:0] u;
  localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(1) << UNIT_F;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qp[c] = {1'b0, dv_r[Q_W].q[c]} + 1'b1;
      mg[c] = qp[c][Q_W:1];
      if (!dv_r[Q_W].sgn[c]) begin
        if (mg[c] > UNIT_ONE - 1'b1) mg[c] = UNIT_ONE - 1'b1;
        u[c] = OUT_W'(mg[c]);
      end else begin
        if (mg[c] > UNIT_ONE) mg[c] = UNIT_ONE;
        u[c] = OUT_W'(Q_W'(0) - mg[c]);
      end
      if (dv_r[Q_W].zero) u[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.unit_x      <= u[0];
      out_r.unit_y      <= u[1];
      out_r.unit_z      <= u[2];
      out_r.zero_length <= dv_r[Q_W].zero;
    end
  end

endmodule

### hdl/normalized_cross_product.sv
// normalized_cross_product: top level joining front end, mid queue and back end.
// Depends on ncp_pkg, ncp_front, ncp_fifo and ncp_back.
//
// Usage:
//   Input channel: in_data holds op and the two vectors; a beat is taken at a
//   rising edge with in_push high and in_full low. op 0 normalises a, op 1
//   normalises a x b.
//   Result channel: while out_empty is low, out_data holds the oldest result;
//   it is taken at a rising edge with out_pop high.
//   Throughput: one beat per cycle, sustained while the result channel does not stall.
//   Path: the beat passes one input register, the queue, three
//   magnitude/square/sum stages, a 32-stage square-root pipeline, a divider
//   load stage, a 17-stage divider pipeline shared by all three components
//   and the result register.
//   Reset (rst_n low, synchronous) empties the queue and all pipeline stages.
//   When the receiver stalls, the back pipeline holds in place; the four-entry
//   queue then fills and in_full rises.
module normalized_cross_product import ncp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  logic  q_push, q_full, q_empty;
  vec_t  q_wdata, q_rdata;
  qctl_t q_ctl;

  ncp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wdata)
  );

  ncp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .ctl_i (q_ctl),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  ncp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_ctl     (q_ctl),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.zero_length) |->
      (out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0))
    else $error("zero-length result with nonzero components");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present right after reset");

  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input blocked right after reset");

endmodule
